@@ hdl/sgb_pkg.sv @@
// Package for the separable Gaussian blur: default parameters, register widths and reset
// values, item codes, and the command and status structs between controller and datapath.
// Depends on nothing.
package sgb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_COEF_BITS  = 16;

  localparam int RADIUS_REG_W = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int DATA_W       = 32;
  localparam int PADDR_W      = 5;

  localparam int RST_RADIUS   = 1;
  localparam int RST_COEF_C   = 32768;
  localparam int RST_COEF_1   = 16384;
  localparam int RST_COEF_2   = 0;
  localparam int RST_COEF_3   = 0;
  localparam int RST_MIRROR   = 0;
  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic accept;
    logic setup;
    logic eval;
    logic row_init;
    logic row_start;
    logic fold_step;
    logic row_base;
    logic tap_start;
    logic tap_read;
    logic tap_acc;
    logic dx_inc;
    logic row_acc;
    logic dy_inc;
    logic finish;
  } sgb_cmd_t;

  typedef struct packed {
    logic need_setup;
    logic emit;
    logic fold_in;
    logic mirror;
    logic dx_last;
    logic dy_last;
    logic out_busy;
  } sgb_sts_t;

endpackage

@@ hdl/sgb_if.sv @@
// Stream interfaces of the blur: the pixel channel and the result channel.
// Fixed 8-bit payload fields; no dependencies.
interface sgb_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pix_ch0;
  logic [7:0] pix_ch1;
  logic [7:0] pix_ch2;
  modport source (output valid, output command, output pix_ch0, output pix_ch1,
                  output pix_ch2, input ready);
  modport sink   (input valid, input command, input pix_ch0, input pix_ch1,
                  input pix_ch2, output ready);
endinterface

interface sgb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic       frame_done;
  modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                  output frame_done, input ready);
  modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                  input frame_done, output ready);
endinterface

@@ hdl/sgb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hdl/sgb_ctrl.sv @@
// Sequencer of the blur: accepts items and steps the datapath through the rows and taps
// of one output pixel. Depends on sgb_pkg.
module sgb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgb_pkg::sgb_sts_t sts,
  output sgb_pkg::sgb_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_EVAL, S_ROW_START, S_ROW_FOLD, S_ROW_BASE,
    S_TAP_START, S_TAP_FOLD, S_TAP_ACC, S_ROW_ACC, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_setup ? S_SETUP : S_EVAL;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.emit) begin
          cmd.row_init = 1'b1;
          state_nxt    = S_ROW_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROW_START: begin
        cmd.row_start = 1'b1;
        state_nxt     = S_ROW_FOLD;
      end
      S_ROW_FOLD: begin
        if (sts.fold_in) begin
          state_nxt = S_ROW_BASE;
        end else if (sts.mirror) begin
          cmd.fold_step = 1'b1;
        end else if (sts.dy_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.dy_inc = 1'b1;
          state_nxt  = S_ROW_START;
        end
      end
      S_ROW_BASE: begin
        cmd.row_base = 1'b1;
        state_nxt    = S_TAP_START;
      end
      S_TAP_START: begin
        cmd.tap_start = 1'b1;
        state_nxt     = S_TAP_FOLD;
      end
      S_TAP_FOLD: begin
        if (sts.fold_in) begin
          cmd.tap_read = 1'b1;
          state_nxt    = S_TAP_ACC;
        end else if (sts.mirror) begin
          cmd.fold_step = 1'b1;
        end else if (sts.dx_last) begin
          state_nxt = S_ROW_ACC;
        end else begin
          cmd.dx_inc = 1'b1;
          state_nxt  = S_TAP_START;
        end
      end
      S_TAP_ACC: begin
        cmd.tap_acc = 1'b1;
        if (sts.dx_last) begin
          state_nxt = S_ROW_ACC;
        end else begin
          cmd.dx_inc = 1'b1;
          state_nxt  = S_TAP_START;
        end
      end
      S_ROW_ACC: begin
        cmd.row_acc = 1'b1;
        if (sts.dy_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.dy_inc = 1'b1;
          state_nxt  = S_ROW_START;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/sgb_dp.sv @@
// Datapath of the blur: frame bookkeeping, row store, border folding, tap and row
// accumulators and the output register. Depends on sgb_pkg and sgb_ram.
module sgb_dp #(
  parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS,
  parameter int COEF_BITS  = sgb_pkg::DEF_COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sgb_pkg::sgb_cmd_t                 cmd,
  output sgb_pkg::sgb_sts_t                 sts,
  input  logic [sgb_pkg::RADIUS_REG_W-1:0]  cfg_radius,
  input  logic [COEF_BITS-1:0]              cfg_coef_c,
  input  logic [COEF_BITS-1:0]              cfg_coef_1,
  input  logic [COEF_BITS-1:0]              cfg_coef_2,
  input  logic [COEF_BITS-1:0]              cfg_coef_3,
  input  logic                              cfg_mirror,
  input  logic [sgb_pkg::WIDTH_REG_W-1:0]   cfg_width,
  input  logic [sgb_pkg::HEIGHT_REG_W-1:0]  cfg_height,
  input  logic                              in_command,
  input  logic [7:0]                        in_ch0,
  input  logic [7:0]                        in_ch1,
  input  logic [7:0]                        in_ch2,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [7:0]                        out_ch0,
  output logic [7:0]                        out_ch1,
  output logic [7:0]                        out_ch2,
  output logic                              out_frame_done
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int RB    = $clog2(MAX_RADIUS + 1);
  localparam int DB    = RB + 1;
  localparam int HB    = sgb_pkg::HEIGHT_REG_W;
  localparam int TB    = WB + HB;
  localparam int CW    = HB + 2;
  localparam int LAGB  = RB + WB + 1;
  localparam int TAPS  = 2 * MAX_RADIUS + 1;
  localparam int TAPB  = $clog2(TAPS + 1);
  localparam int HSW   = 8 + COEF_BITS + TAPB;
  localparam int ACW   = HSW + COEF_BITS + TAPB;
  localparam int SH    = 2 * COEF_BITS;
  localparam int RING  = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2;
  localparam int AW    = $clog2(RING);
  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {PH_IDLE, PH_FILL, PH_DRAIN} phase_t;

  phase_t                phase_r;
  logic [RB-1:0]         act_rad_r;
  logic [WB-1:0]         act_w_r;
  logic [HB-1:0]         act_h_r;
  logic                  act_mir_r;
  logic [TB-1:0]         total_r;
  logic [LAGB-1:0]       lag_r;
  logic [TB-1:0]         in_cnt_r;
  logic [TB-1:0]         out_idx_r;
  logic [HB-1:0]         orow_r;
  logic [WB-1:0]         ocol_r;
  logic signed [DB-1:0]  dy_r;
  logic signed [DB-1:0]  dx_r;
  logic signed [CW-1:0]  fold_v_r;
  logic [HB-1:0]         fold_n_r;
  logic [TB-1:0]         base_r;
  logic [HSW-1:0]        hs_r [3];
  logic [ACW-1:0]        acc_r [3];
  logic                  out_valid_r;
  logic [7:0]            out_ch_r [3];
  logic                  out_done_r;

  logic [RB-1:0]         rad_clip;
  logic [WB-1:0]         w_clip;
  logic [HB-1:0]         h_clip;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [23:0]           rd_data;
  logic                  fill_done;
  logic [TB:0]           due_idx;
  logic [TB:0]           idx_inc;
  logic                  last_out;
  logic [RB-1:0]         dx_abs;
  logic [RB-1:0]         dy_abs;
  logic [COEF_BITS-1:0]  wt_x;
  logic [COEF_BITS-1:0]  wt_y;
  logic [CW-1:0]         two_n_m1;
  logic signed [DB-1:0]  rad_s;
  logic [ACW:0]          rnd [3];
  logic [7:0]            sat [3];

  function automatic logic [COEF_BITS-1:0] pick_weight(input logic [RB-1:0] d,
      input logic [COEF_BITS-1:0] c0, input logic [COEF_BITS-1:0] c1,
      input logic [COEF_BITS-1:0] c2, input logic [COEF_BITS-1:0] c3);
    logic [COEF_BITS-1:0] w;
    if (int'(d) == 0) begin
      w = c0;
    end else if (int'(d) == 1) begin
      w = c1;
    end else if (int'(d) == 2) begin
      w = c2;
    end else begin
      w = c3;
    end
    return w;
  endfunction

  always_comb begin
    rad_clip = (int'(cfg_radius) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(cfg_radius);
    if (cfg_width == '0) begin
      w_clip = WB'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w_clip = WB'(MAX_WIDTH);
    end else begin
      w_clip = WB'(cfg_width);
    end
    h_clip = (cfg_height == '0) ? HB'(1) : cfg_height;
  end

  assign wr_en   = cmd.accept && (in_command == sgb_pkg::CMD_PIXEL) && (phase_r != PH_DRAIN);
  assign wr_addr = (phase_r == PH_IDLE) ? '0 : in_cnt_r[AW-1:0];
  assign rd_addr = base_r[AW-1:0] + fold_v_r[AW-1:0];

  sgb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_row_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_ch2, in_ch1, in_ch0}),
    .re    (cmd.tap_read),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rad_s     = $signed({1'b0, act_rad_r});
  assign fill_done = (phase_r == PH_FILL) && (in_cnt_r >= total_r);
  assign due_idx   = {1'b0, out_idx_r} + (TB + 1)'(lag_r);
  assign idx_inc   = {1'b0, out_idx_r} + (TB + 1)'(1);
  assign last_out  = (phase_r == PH_DRAIN) && (idx_inc >= {1'b0, total_r});
  assign two_n_m1  = CW'({fold_n_r, 1'b0}) - CW'(1);
  assign dx_abs    = dx_r[DB-1] ? RB'(-dx_r) : RB'(dx_r);
  assign dy_abs    = dy_r[DB-1] ? RB'(-dy_r) : RB'(dy_r);
  assign wt_x      = pick_weight(dx_abs, cfg_coef_c, cfg_coef_1, cfg_coef_2, cfg_coef_3);
  assign wt_y      = pick_weight(dy_abs, cfg_coef_c, cfg_coef_1, cfg_coef_2, cfg_coef_3);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = (ACW + 1)'(acc_r[c]) + ((ACW + 1)'(1) << (SH - 1));
      sat[c] = (|rnd[c][ACW:SH+8]) ? 8'hFF : rnd[c][SH+7:SH];
    end
  end

  always_comb begin
    sts.need_setup = (phase_r == PH_IDLE) && (in_command == sgb_pkg::CMD_PIXEL);
    sts.emit       = (phase_r == PH_DRAIN) || fill_done ||
                     ((phase_r == PH_FILL) && ({1'b0, in_cnt_r} > due_idx));
    sts.fold_in    = !fold_v_r[CW-1] && (fold_v_r[CW-2:0] < (CW - 1)'(fold_n_r));
    sts.mirror     = act_mir_r;
    sts.dx_last    = (dx_r == rad_s);
    sts.dy_last    = (dy_r == rad_s);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      act_rad_r   <= '0;
      act_w_r     <= WB'(1);
      act_h_r     <= HB'(1);
      act_mir_r   <= 1'b0;
      in_cnt_r    <= '0;
      out_idx_r   <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        if (phase_r == PH_IDLE) begin
          phase_r   <= PH_FILL;
          act_rad_r <= rad_clip;
          act_w_r   <= w_clip;
          act_h_r   <= h_clip;
          act_mir_r <= cfg_mirror;
          in_cnt_r  <= TB'(1);
          out_idx_r <= '0;
          orow_r    <= '0;
          ocol_r    <= '0;
        end else begin
          in_cnt_r <= in_cnt_r + TB'(1);
        end
      end
      if (cmd.eval && fill_done) begin
        phase_r <= PH_DRAIN;
      end
      if (cmd.finish) begin
        out_idx_r <= idx_inc[TB-1:0];
        if (ocol_r == act_w_r - WB'(1)) begin
          ocol_r <= '0;
          orow_r <= orow_r + HB'(1);
        end else begin
          ocol_r <= ocol_r + WB'(1);
        end
        if (last_out) begin
          phase_r <= PH_IDLE;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      total_r <= TB'(act_w_r) * TB'(act_h_r);
      lag_r   <= LAGB'(act_rad_r) * LAGB'(act_w_r) + LAGB'(act_rad_r);
    end
    if (cmd.row_init) begin
      dy_r <= -rad_s;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end
    if (cmd.dy_inc) begin
      dy_r <= dy_r + $signed(DB'(1));
    end
    if (cmd.row_start) begin
      fold_v_r <= $signed(CW'(orow_r)) + CW'(dy_r);
      fold_n_r <= act_h_r;
    end
    if (cmd.tap_start) begin
      fold_v_r <= $signed(CW'(ocol_r)) + CW'(dx_r);
      fold_n_r <= HB'(act_w_r);
    end
    if (cmd.fold_step) begin
      if (fold_v_r[CW-1]) begin
        fold_v_r <= ~fold_v_r;
      end else begin
        fold_v_r <= $signed(two_n_m1) - fold_v_r;
      end
    end
    if (cmd.row_base) begin
      base_r <= TB'(fold_v_r[HB-1:0]) * TB'(act_w_r);
      dx_r   <= -rad_s;
      for (int c = 0; c < 3; c++) begin
        hs_r[c] <= '0;
      end
    end
    if (cmd.dx_inc) begin
      dx_r <= dx_r + $signed(DB'(1));
    end
    if (cmd.tap_acc) begin
      for (int c = 0; c < 3; c++) begin
        hs_r[c] <= hs_r[c] + HSW'(wt_x) * HSW'(rd_data[8*c +: 8]);
      end
    end
    if (cmd.row_acc) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + ACW'(wt_y) * ACW'(hs_r[c]);
      end
    end
    if (cmd.finish) begin
      for (int c = 0; c < 3; c++) begin
        out_ch_r[c] <= sat[c];
      end
      out_done_r <= last_out;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ch0        = out_ch_r[0];
  assign out_ch1        = out_ch_r[1];
  assign out_ch2        = out_ch_r[2];
  assign out_frame_done = out_done_r;

endmodule

@@ hdl/separable_gaussian_blur.sv @@
// Separable Gaussian blur: an item that yields no result is accepted and evaluated, with a
// setup step first at a frame start; one that yields a pixel then also walks the rows and
// taps of its window, with a fold step per mirror reflection and any wait on a busy output.
// A zero-padded tap or row outside the frame is skipped. One item is in flight at a time.
// Reset clears the registers to their listed values and closes any frame; the row
// store is not cleared. Depends on sgb_pkg, sgb_if, sgb_ram, sgb_ctrl and sgb_dp.
module separable_gaussian_blur #(
  parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS,
  parameter int COEF_BITS  = sgb_pkg::DEF_COEF_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sgb_pix_if.sink                      in_s,
  sgb_res_if.source                    out_s,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sgb_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [sgb_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [sgb_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_COEF_C = 3'd1;
  localparam logic [2:0] REG_COEF_1 = 3'd2;
  localparam logic [2:0] REG_COEF_2 = 3'd3;
  localparam logic [2:0] REG_COEF_3 = 3'd4;
  localparam logic [2:0] REG_MIRROR = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam int DW = sgb_pkg::DATA_W;

  logic [sgb_pkg::RADIUS_REG_W-1:0] radius_r;
  logic [COEF_BITS-1:0]             coef_c_r;
  logic [COEF_BITS-1:0]             coef_1_r;
  logic [COEF_BITS-1:0]             coef_2_r;
  logic [COEF_BITS-1:0]             coef_3_r;
  logic                             mirror_r;
  logic [sgb_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [sgb_pkg::HEIGHT_REG_W-1:0] height_r;

  logic                             cfg_wr;
  logic [2:0]                       reg_idx;
  sgb_pkg::sgb_cmd_t                cmd;
  sgb_pkg::sgb_sts_t                sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= sgb_pkg::RADIUS_REG_W'(sgb_pkg::RST_RADIUS);
      coef_c_r <= COEF_BITS'(sgb_pkg::RST_COEF_C);
      coef_1_r <= COEF_BITS'(sgb_pkg::RST_COEF_1);
      coef_2_r <= COEF_BITS'(sgb_pkg::RST_COEF_2);
      coef_3_r <= COEF_BITS'(sgb_pkg::RST_COEF_3);
      mirror_r <= 1'(sgb_pkg::RST_MIRROR);
      width_r  <= sgb_pkg::WIDTH_REG_W'(sgb_pkg::RST_WIDTH);
      height_r <= sgb_pkg::HEIGHT_REG_W'(sgb_pkg::RST_HEIGHT);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RADIUS: radius_r <= cfg_pwdata[sgb_pkg::RADIUS_REG_W-1:0];
        REG_COEF_C: coef_c_r <= cfg_pwdata[COEF_BITS-1:0];
        REG_COEF_1: coef_1_r <= cfg_pwdata[COEF_BITS-1:0];
        REG_COEF_2: coef_2_r <= cfg_pwdata[COEF_BITS-1:0];
        REG_COEF_3: coef_3_r <= cfg_pwdata[COEF_BITS-1:0];
        REG_MIRROR: mirror_r <= cfg_pwdata[0];
        REG_WIDTH:  width_r  <= cfg_pwdata[sgb_pkg::WIDTH_REG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[sgb_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS: cfg_prdata = DW'(radius_r);
      REG_COEF_C: cfg_prdata = DW'(coef_c_r);
      REG_COEF_1: cfg_prdata = DW'(coef_1_r);
      REG_COEF_2: cfg_prdata = DW'(coef_2_r);
      REG_COEF_3: cfg_prdata = DW'(coef_3_r);
      REG_MIRROR: cfg_prdata = DW'(mirror_r);
      REG_WIDTH:  cfg_prdata = DW'(width_r);
      REG_HEIGHT: cfg_prdata = DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  sgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_radius     (radius_r),
    .cfg_coef_c     (coef_c_r),
    .cfg_coef_1     (coef_1_r),
    .cfg_coef_2     (coef_2_r),
    .cfg_coef_3     (coef_3_r),
    .cfg_mirror     (mirror_r),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .in_command     (in_s.command),
    .in_ch0         (in_s.pix_ch0),
    .in_ch1         (in_s.pix_ch1),
    .in_ch2         (in_s.pix_ch2),
    .out_ready      (out_s.ready),
    .out_valid      (out_s.valid),
    .out_ch0        (out_s.out_ch0),
    .out_ch1        (out_s.out_ch1),
    .out_ch2        (out_s.out_ch2),
    .out_frame_done (out_s.frame_done)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for separable_gaussian_blur: drives pixel and flush beats, predicts every
// filtered pixel in SystemVerilog and checks each result beat in order.
// Depends on sgb_pkg, sgb_if and the blur RTL.
module tb_top;

  localparam int MAXW      = sgb_pkg::DEF_MAX_WIDTH;
  localparam int MAXR      = sgb_pkg::DEF_MAX_RADIUS;
  localparam int CBITS     = sgb_pkg::DEF_COEF_BITS;
  localparam int RING      = 2 * (MAXR * MAXW + MAXR) + 2;
  localparam int SETTLE    = 400;
  localparam int WDOG_MAX  = 20000;

  localparam logic [sgb_pkg::PADDR_W-1:0] A_RADIUS = 5'd0;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_COEF_C = 5'd4;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_COEF_1 = 5'd8;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_COEF_2 = 5'd12;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_COEF_3 = 5'd16;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_MIRROR = 5'd20;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_WIDTH  = 5'd24;
  localparam logic [sgb_pkg::PADDR_W-1:0] A_HEIGHT = 5'd28;

  typedef enum int {FR_IDLE, FR_FILL, FR_DRAIN} frame_phase_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       done;
  } blur_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [sgb_pkg::PADDR_W-1:0]  cfg_paddr = '0;
  logic [sgb_pkg::DATA_W-1:0]   cfg_pwdata = '0;
  logic [sgb_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  sgb_pix_if pix ();
  sgb_res_if res ();

  separable_gaussian_blur dut (
    .clk(clk), .rst_n(rst_n), .in_s(pix), .out_s(res),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and predictor state.
  logic [1:0]  r_radius;
  logic [15:0] r_coef [4];
  logic        r_mirror;
  logic [10:0] r_width;
  logic [15:0] r_height;

  logic [23:0]  pix_ring [RING];
  frame_phase_t fphase;
  int unsigned  lat_r, lat_w, lat_h, n_in, n_out;
  logic         lat_mirror;

  blur_px_t blur_q [$];
  int  errors = 0;
  int  send_idle = 0, recv_idle = 0;
  int  stall_cycles = 0;
  int  items_sent = 0;

  function automatic bit fold_coord(input int v, input int n, output int res_v);
    int p, m;
    if (v >= 0 && v < n) begin
      res_v = v;
      return 1'b1;
    end
    res_v = 0;
    if (!lat_mirror) return 1'b0;
    p = 2 * n;
    m = ((v % p) + p) % p;
    if (m >= n) m = p - 1 - m;
    res_v = m;
    return 1'b1;
  endfunction

  function automatic blur_px_t blur_at(input int unsigned k);
    blur_px_t o;
    longint unsigned acc [3], hs [3], v;
    int orow, ocol, y, x;
    logic [23:0] p;
    orow = k / lat_w;
    ocol = k % lat_w;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int dy = -int'(lat_r); dy <= int'(lat_r); dy++) begin
      for (int c = 0; c < 3; c++) hs[c] = 0;
      if (!fold_coord(orow + dy, lat_h, y)) continue;
      for (int dx = -int'(lat_r); dx <= int'(lat_r); dx++) begin
        if (!fold_coord(ocol + dx, lat_w, x)) continue;
        p = pix_ring[(y * lat_w + x) % RING];
        for (int c = 0; c < 3; c++)
          hs[c] += longint'(r_coef[dx < 0 ? -dx : dx]) * p[8*c +: 8];
      end
      for (int c = 0; c < 3; c++) acc[c] += longint'(r_coef[dy < 0 ? -dy : dy]) * hs[c];
    end
    for (int c = 0; c < 3; c++) begin
      v = (acc[c] + (64'd1 << (2 * CBITS - 1))) >> (2 * CBITS);
      if (v > 255) v = 255;
      if (c == 0) o.c0 = v[7:0];
      else if (c == 1) o.c1 = v[7:0];
      else o.c2 = v[7:0];
    end
    o.done = 1'b0;
    return o;
  endfunction

  task automatic predict_beat(input logic cmd, input logic [23:0] p);
    blur_px_t o;
    if (cmd == sgb_pkg::CMD_PIXEL && fphase != FR_DRAIN) begin
      if (fphase == FR_IDLE) begin
        lat_r = r_radius > MAXR ? MAXR : r_radius;
        lat_w = r_width == 0 ? 1 : (r_width > MAXW ? MAXW : r_width);
        lat_h = r_height == 0 ? 1 : r_height;
        lat_mirror = r_mirror;
        n_in = 0;
        n_out = 0;
        fphase = FR_FILL;
      end
      pix_ring[n_in % RING] = p;
      n_in++;
      if (n_in >= lat_w * lat_h) fphase = FR_DRAIN;
    end
    if (fphase == FR_DRAIN ||
        (fphase == FR_FILL && n_in > n_out + lat_r * lat_w + lat_r)) begin
      o = blur_at(n_out);
      n_out++;
      if (fphase == FR_DRAIN && n_out >= lat_w * lat_h) begin
        o.done = 1'b1;
        fphase = FR_IDLE;
      end
      blur_q = {blur_q, o};
    end
  endtask

  task automatic send_beat(input logic cmd, input logic [23:0] p);
    pix.valid   <= 1'b1;
    pix.command <= cmd;
    pix.pix_ch0 <= p[7:0];
    pix.pix_ch1 <= p[15:8];
    pix.pix_ch2 <= p[23:16];
    do @(posedge clk); while (!pix.ready);
    predict_beat(cmd, p);
    items_sent++;
    if ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sgb_pkg::PADDR_W-1:0] a,
                           input logic [sgb_pkg::DATA_W-1:0] d);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (a)
      A_RADIUS: r_radius  = d[1:0];
      A_COEF_C: r_coef[0] = d[15:0];
      A_COEF_1: r_coef[1] = d[15:0];
      A_COEF_2: r_coef[2] = d[15:0];
      A_COEF_3: r_coef[3] = d[15:0];
      A_MIRROR: r_mirror  = d[0];
      A_WIDTH:  r_width   = d[10:0];
      A_HEIGHT: r_height  = d[15:0];
      default: ;
    endcase
  endtask

  task automatic setup_frame(input int w, input int h, input int r, input int m,
                             input int c0, input int c1, input int c2, input int c3);
    wait_drained();
    write_reg(A_WIDTH, w);
    write_reg(A_HEIGHT, h);
    write_reg(A_RADIUS, r);
    write_reg(A_MIRROR, m);
    write_reg(A_COEF_C, c0);
    write_reg(A_COEF_1, c1);
    write_reg(A_COEF_2, c2);
    write_reg(A_COEF_3, c3);
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_px();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic int lat_w_of(input logic [10:0] w);
    return w == 0 ? 1 : (w > MAXW ? MAXW : w);
  endfunction

  // Pixels of one frame, then flushes (some replaced by stray pixels) until it is drained.
  task automatic stream_frame(input bit pause_once);
    int total, pause_at;
    total = lat_w_of(r_width) * (r_height == 0 ? 1 : r_height);
    pause_at = pause_once ? $urandom_range(total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) begin
        pix.valid <= 1'b0;
        @(posedge clk);
        while (blur_q.size() != 0) @(posedge clk);
      end
      send_beat(sgb_pkg::CMD_PIXEL, rand_px());
    end
    while (fphase == FR_DRAIN) begin
      if ($urandom_range(9) == 0) send_beat(sgb_pkg::CMD_PIXEL, rand_px());
      else send_beat(sgb_pkg::CMD_FLUSH, 24'($urandom()));
    end
    if ($urandom_range(3) == 0) send_beat(sgb_pkg::CMD_FLUSH, 24'($urandom()));
  endtask

  task automatic test_single_pixel();
    setup_frame(1, 1, 0, 0, 65535, 0, 0, 0);
    send_beat(sgb_pkg::CMD_FLUSH, 24'h123456);
    send_beat(sgb_pkg::CMD_PIXEL, 24'hFFFFFF);
    setup_frame(0, 0, 1, 1, 65535, 65535, 0, 0);
    send_beat(sgb_pkg::CMD_PIXEL, 24'h00FF80);
    send_beat(sgb_pkg::CMD_FLUSH, 24'h000000);
  endtask

  task automatic test_small_frames();
    setup_frame(3, 2, 1, 0, 32768, 16384, 0, 0);
    stream_frame(0);
    setup_frame(2, 3, 3, 1, 20000, 15000, 8000, 3000);
    stream_frame(0);
    setup_frame(4, 1, 2, 1, 65535, 65535, 65535, 65535);
    stream_frame(0);
  endtask

  task automatic test_limits();
    setup_frame(2047, 1, 0, 1, 40000, 16384, 0, 0);
    stream_frame(0);
    setup_frame(1, 65535, 2, 0, 0, 0, 0, 0);
    setup_frame(1, 3, 2, 0, 0, 0, 0, 0);
    stream_frame(0);
  endtask

  task automatic test_random(input int budget);
    int w, h, r, c1, c2, c3, stop_at;
    bit paused;
    paused = 1'b0;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      w = $urandom_range(3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      r = $urandom_range(3);
      if ($urandom_range(3) == 0) begin
        setup_frame(w, h, r, $urandom_range(1), $urandom(), $urandom(), $urandom(),
                    $urandom());
      end else begin
        c1 = $urandom_range(16000);
        c2 = $urandom_range(8000);
        c3 = $urandom_range(3000);
        setup_frame(w, h, r, $urandom_range(1), 65536 - 2 * (c1 + c2 + c3), c1, c2, c3);
      end
      stream_frame(!paused);
      paused = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (res.valid && res.ready) begin
      if (blur_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h %h %h %b", $time,
                 res.out_ch0, res.out_ch1, res.out_ch2, res.frame_done);
        errors++;
      end else begin
        if ({res.out_ch0, res.out_ch1, res.out_ch2, res.frame_done} != blur_q[0]) begin
          $display("%0t: mismatch, expected %h %h %h %b, actual %h %h %h %b", $time,
                   blur_q[0].c0, blur_q[0].c1, blur_q[0].c2, blur_q[0].done,
                   res.out_ch0, res.out_ch1, res.out_ch2, res.frame_done);
          errors++;
        end
        void'(blur_q.pop_front());
      end
    end
    res.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
        (blur_q.size() == 0 && !pix.valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WDOG_MAX) begin
      $display("** separable_gaussian_blur: FAILED **");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.command = sgb_pkg::CMD_PIXEL;
    pix.pix_ch0 = '0;
    pix.pix_ch1 = '0;
    pix.pix_ch2 = '0;
    r_radius = 2'(sgb_pkg::RST_RADIUS);
    r_coef[0] = 16'(sgb_pkg::RST_COEF_C);
    r_coef[1] = 16'(sgb_pkg::RST_COEF_1);
    r_coef[2] = 16'(sgb_pkg::RST_COEF_2);
    r_coef[3] = 16'(sgb_pkg::RST_COEF_3);
    r_mirror = 1'(sgb_pkg::RST_MIRROR);
    r_width = 11'(sgb_pkg::RST_WIDTH);
    r_height = 16'(sgb_pkg::RST_HEIGHT);
    fphase = FR_IDLE;
    lat_r = 0;
    lat_w = 1;
    lat_h = 1;
    lat_mirror = 1'b0;
    n_in = 0;
    n_out = 0;
    for (int i = 0; i < RING; i++) pix_ring[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 11;
    recv_idle = 85;
    test_single_pixel();
    test_small_frames();
    send_idle = 85;
    recv_idle = 11;
    test_limits();
    send_idle = 0;
    recv_idle = 0;
    test_random(40);
    wait_drained();
    if (errors == 0) begin
      $display("** separable_gaussian_blur: PASSED **");
    end else begin
      $display("** separable_gaussian_blur: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sgb_pkg.sv
hdl/sgb_if.sv
hdl/sgb_ram.sv
hdl/sgb_ctrl.sv
hdl/sgb_dp.sv
hdl/separable_gaussian_blur.sv
test/tb_top.sv
